// ===== src/banned_word_and_char_filter_core_assert.svh =====
// Assertion macros for the banned word filter.
// Used by modules that include this header; expects clk and rst_n in scope.
`ifndef BANNED_WORD_AND_CHAR_FILTER_CORE_ASSERT_SVH
`define BANNED_WORD_AND_CHAR_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BWF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BWF_ASSERT(lbl, prop, msg)
`define BWF_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/bwf_pkg.sv =====
// Shared types, codes and byte helpers for the banned word filter.
// No dependencies.
`default_nettype none
package bwf_pkg;
  localparam int DEF_MAX_WORDS    = 32;
  localparam int DEF_MAX_WORD_LEN = 24;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_PAT    = 2'd1;
  localparam logic [1:0] REQ_TEXT   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_ABUSE = 2'd1;
  localparam logic [1:0] CAUSE_NAME  = 2'd2;
  localparam logic [1:0] CAUSE_CHAR  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       tag;
    logic       last;
    logic       name;
  } bwf_item_t;

  function automatic logic [7:0] fold8(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
    return c;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    logic f;
    f = (c <= 8'd32);
    case (c)
      8'h60, 8'h5c, 8'h3b, 8'h2c, 8'h2e, 8'h27, 8'h2f, 8'h21, 8'h25,
      8'h5e, 8'h26, 8'h7c, 8'h3a, 8'h22, 8'h3c, 8'h3e, 8'h3f: f = 1'b1;
      default: ;
    endcase
    return f;
  endfunction
endpackage
`default_nettype wire

// ===== src/bwf_in_if.sv =====
// Input and result channel interfaces for the banned word filter.
// No dependencies.
`default_nettype none
interface bwf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       name_only_word;
  logic       last_byte;
  logic       check_name;
  modport source(output valid, req_type, data_byte, name_only_word, last_byte, check_name,
                 input ready);
  modport sink(input valid, req_type, data_byte, name_only_word, last_byte, check_name,
               output ready);
endinterface

interface bwf_out_if;
  logic       valid;
  logic       ready;
  logic       text_valid;
  logic [1:0] cause;
  logic [4:0] word_index;
  logic [7:0] bad_char;
  logic       table_overflow;
  modport source(output valid, text_valid, cause, word_index, bad_char, table_overflow,
                 input ready);
  modport sink(input valid, text_valid, cause, word_index, bad_char, table_overflow,
               output ready);
endinterface
`default_nettype wire

// ===== src/bwf_queue.sv =====
// Front end: accepts requests, drops unused codes, queues items (two entries).
// Depends on bwf_pkg and bwf_in_if.
`default_nettype none
module bwf_queue
  import bwf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bwf_in_if.sink     in_ch,
  output bwf_item_t  q_item,
  output logic       q_valid,
  input  wire logic  q_pop
);
  bwf_item_t  q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (in_ch.req_type != REQ_UNUSED);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{kind: in_ch.req_type, data: in_ch.data_byte,
                     tag: in_ch.name_only_word, last: in_ch.last_byte,
                     name: in_ch.check_name};
    end
  end
endmodule
`default_nettype wire

// ===== src/bwf_engine.sv =====
// Back end: pattern store, per-word shift-and scan, verdict and result register.
// Depends on bwf_pkg, bwf_out_if and the assertion header.
`default_nettype none
`include "banned_word_and_char_filter_core_assert.svh"
module bwf_engine
  import bwf_pkg::*;
#(
  parameter int MAX_WORDS    = DEF_MAX_WORDS,
  parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bwf_item_t  q_item,
  input  wire logic       q_valid,
  output logic            q_pop,
  bwf_out_if.source       out_ch
);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int WI = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int CI = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int RW = MAX_WORD_LEN * 8 + LW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [RW-1:0]           mem [MAX_WORDS];
  logic [RW-1:0]           row_r;
  logic [7:0]              lbuf_r [MAX_WORD_LEN];
  logic [MAX_WORD_LEN-1:0] pm_r [MAX_WORDS];
  logic [MAX_WORDS-1:0]    pm_vld_r, hit_r, tag_r;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, w_r, w_nxt;
  logic [LW-1:0] cursor_r, cursor_nxt;
  logic          ovf_r, ovf_nxt;
  logic          bad_v_r, bad_v_nxt;
  logic [7:0]    bad_r, bad_nxt;
  logic [7:0]    fb_r, fb_nxt;
  logic          last_r, last_nxt, name_r, name_nxt;
  logic          ab_f_r, ab_f_nxt, nm_f_r, nm_f_nxt;
  logic [WI-1:0] ab_i_r, ab_i_nxt, nm_i_r, nm_i_nxt;
  logic          out_v_r, out_v_nxt;

  logic [WI-1:0] widx;
  logic          load_now, load_room, load_done, text_clr, word_clr;
  logic [RW-1:0] wrow;
  logic [LW-1:0] cur_inc;
  logic [LW-1:0] row_len;
  logic [MAX_WORD_LEN-1:0] old_pm, new_pm;
  logic          word_hit_now, slot_free;
  logic          v_fail;
  logic [1:0]    v_cause;
  logic [WI-1:0] v_idx;
  logic [WI+4:0] v_idx_ext;

  assign widx      = w_r[WI-1:0];
  assign load_now  = (state_r == ST_IDLE) && q_valid && (q_item.kind == REQ_PAT);
  assign load_room = (count_r != CW'(MAX_WORDS));
  assign load_done = load_now && load_room && q_item.last;
  assign cur_inc   = (cursor_r < LW'(MAX_WORD_LEN)) ? cursor_r + LW'(1) : cursor_r;
  assign slot_free = !out_v_r || out_ch.ready;
  assign word_clr  = (state_r == ST_IDLE) && q_valid && (q_item.kind == REQ_CLEAR);
  assign text_clr  = (state_r == ST_OUT) && slot_free;

  always_comb begin
    wrow = '0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      wrow[i*8 +: 8] = (cursor_r == LW'(i)) ? q_item.data : lbuf_r[i];
    end
    wrow[RW-1 -: LW] = cur_inc;
  end

  always_comb begin
    row_len = row_r[RW-1 -: LW];
    old_pm  = pm_vld_r[widx] ? pm_r[widx] : '0;
    new_pm  = '0;
    word_hit_now = 1'b0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      new_pm[i] = (LW'(i) < row_len) && ((i == 0) || old_pm[(i == 0) ? 0 : i - 1]) &&
                  (fold8(row_r[i*8 +: 8]) == fb_r);
      if (LW'(i + 1) == row_len) word_hit_now = new_pm[i];
    end
    word_hit_now = word_hit_now || hit_r[widx];
  end

  always_comb begin
    v_fail  = 1'b1;
    v_cause = CAUSE_NONE;
    v_idx   = '0;
    if (ab_f_r) begin
      v_cause = CAUSE_ABUSE;
      v_idx   = ab_i_r;
    end else if (name_r && nm_f_r) begin
      v_cause = CAUSE_NAME;
      v_idx   = nm_i_r;
    end else if (name_r && bad_v_r) begin
      v_cause = CAUSE_CHAR;
    end else begin
      v_fail = 1'b0;
    end
    v_idx_ext = {5'd0, v_idx};
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    w_nxt      = w_r;
    cursor_nxt = cursor_r;
    ovf_nxt    = ovf_r;
    bad_v_nxt  = bad_v_r;
    bad_nxt    = bad_r;
    fb_nxt     = fb_r;
    last_nxt   = last_r;
    name_nxt   = name_r;
    ab_f_nxt   = ab_f_r;
    ab_i_nxt   = ab_i_r;
    nm_f_nxt   = nm_f_r;
    nm_i_nxt   = nm_i_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    q_pop      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            REQ_CLEAR: begin
              count_nxt  = '0;
              cursor_nxt = '0;
              ovf_nxt    = 1'b0;
              bad_v_nxt  = 1'b0;
              bad_nxt    = '0;
            end
            REQ_PAT: begin
              if (!load_room) begin
                ovf_nxt = 1'b1;
              end else begin
                if (cursor_r == LW'(MAX_WORD_LEN)) ovf_nxt = 1'b1;
                cursor_nxt = cur_inc;
                if (q_item.last) begin
                  count_nxt  = count_r + CW'(1);
                  cursor_nxt = '0;
                end
              end
            end
            default: begin
              if (!bad_v_r && is_forbidden(q_item.data)) begin
                bad_v_nxt = 1'b1;
                bad_nxt   = q_item.data;
              end
              fb_nxt   = fold8(q_item.data);
              last_nxt = q_item.last;
              name_nxt = q_item.name;
              w_nxt    = '0;
              ab_f_nxt = 1'b0;
              nm_f_nxt = 1'b0;
              if (count_r != '0)   state_nxt = ST_RD;
              else if (q_item.last) state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_RD: state_nxt = ST_UPD;
      ST_UPD: begin
        if (word_hit_now && !tag_r[widx] && !ab_f_r) begin
          ab_f_nxt = 1'b1;
          ab_i_nxt = widx;
        end
        if (word_hit_now && tag_r[widx] && !nm_f_r) begin
          nm_f_nxt = 1'b1;
          nm_i_nxt = widx;
        end
        w_nxt = w_r + CW'(1);
        if (w_nxt != count_r) state_nxt = ST_RD;
        else if (last_r)      state_nxt = ST_OUT;
        else                  state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_v_nxt = 1'b1;
          bad_v_nxt = 1'b0;
          bad_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      w_r      <= '0;
      cursor_r <= '0;
      ovf_r    <= 1'b0;
      bad_v_r  <= 1'b0;
      bad_r    <= '0;
      ab_f_r   <= 1'b0;
      nm_f_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pm_vld_r <= '0;
      hit_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      w_r      <= w_nxt;
      cursor_r <= cursor_nxt;
      ovf_r    <= ovf_nxt;
      bad_v_r  <= bad_v_nxt;
      bad_r    <= bad_nxt;
      ab_f_r   <= ab_f_nxt;
      nm_f_r   <= nm_f_nxt;
      out_v_r  <= out_v_nxt;
      if (word_clr || text_clr) begin
        pm_vld_r <= '0;
        hit_r    <= '0;
      end else if (load_done) begin
        pm_vld_r[count_r[WI-1:0]] <= 1'b0;
        hit_r[count_r[WI-1:0]]    <= 1'b0;
      end else if (state_r == ST_UPD) begin
        pm_vld_r[widx] <= 1'b1;
        hit_r[widx]    <= word_hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    fb_r     <= fb_nxt;
    last_r   <= last_nxt;
    name_r   <= name_nxt;
    ab_i_r   <= ab_i_nxt;
    nm_i_r   <= nm_i_nxt;
    if (state_r == ST_UPD) pm_r[widx] <= new_pm;
    if (load_now && load_room) begin
      tag_r[count_r[WI-1:0]] <= q_item.tag;
      if (cursor_r < LW'(MAX_WORD_LEN)) lbuf_r[cursor_r[CI-1:0]] <= q_item.data;
    end
    if (text_clr) begin
      out_ch.text_valid     <= !v_fail;
      out_ch.cause          <= v_cause;
      out_ch.word_index     <= v_idx_ext[4:0];
      out_ch.bad_char       <= (v_cause == CAUSE_CHAR) ? bad_r : 8'd0;
      out_ch.table_overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_done) mem[count_r[WI-1:0]] <= wrow;
    if (state_r == ST_RD) row_r <= mem[widx];
  end

  assign out_ch.valid = out_v_r;

  `BWF_ASSERT(a_count_bound, (count_r <= CW'(MAX_WORDS)), "word count above capacity")
  `BWF_ASSERT(a_upd_after_rd, (state_r == ST_UPD) |-> ($past(state_r) == ST_RD), "update without read")
  `BWF_ASSERT(a_out_from_verdict, $rose(out_v_r) |-> ($past(state_r) == ST_OUT), "stray result")
  `BWF_NEVER(a_scan_range, (state_r == ST_RD) && (w_r >= count_r), "scan past word count")
endmodule
`default_nettype wire

// ===== src/banned_word_and_char_filter_core.sv =====
// Banned word and forbidden character filter, top level.
// A result follows the last text byte accepted into an empty queue: the engine pops the byte,
// does one memory read and one shift-and update per word, then loads the result register.
// No new text byte is taken until the scan of the last one over all words is done; the last
// byte of a text also waits for the result register, which waits on out ready.
// Pattern and clear bytes are taken directly in idle. Reset (rst_n low, sync) empties all.
`default_nettype none
module banned_word_and_char_filter_core
  import bwf_pkg::*;
#(
  parameter int MAX_WORDS    = DEF_MAX_WORDS,
  parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bwf_in_if.sink    in_ch,
  bwf_out_if.source out_ch
);
  bwf_item_t q_item;
  logic      q_valid, q_pop;

  bwf_queue u_queue (
    .clk, .rst_n, .in_ch, .q_item, .q_valid, .q_pop
  );

  bwf_engine #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_engine (
    .clk, .rst_n, .q_item, .q_valid, .q_pop, .out_ch
  );
endmodule
`default_nettype wire
